[src/pal_pkg.sv]
// Shared types, constants and codes for the positional array list.
package pal_pkg;

   localparam int DEPTH    = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int POS_W    = 6;
   localparam int WORD_W   = 32;
   localparam int CAP_W    = 6;
   localparam int ADDR_W   = 2;
   localparam int CSR_W    = 32;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_INSERT = 2'd2;
   localparam logic [1:0] OP_REMOVE = 2'd3;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   localparam logic [ADDR_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CAP_W-1:0]  CAP_RESET    = 6'd32;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic load;
      logic from_lower;
      logic from_upper;
   } cell_ctrl_type;

endpackage

[src/pal_cell.sv]
// One storage cell of the list row: holds, loads, or takes a neighbor's word.
module pal_cell (
   input  logic                   clock,
   input  pal_pkg::cell_ctrl_type ctrl,
   input  pal_pkg::word_type      load_data,
   input  pal_pkg::word_type      lower_data,
   input  pal_pkg::word_type      upper_data,
   output pal_pkg::word_type      data
);
   import pal_pkg::*;

   word_type data_ff;
   word_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.from_lower) begin
         data_in = lower_data;
      end else if (ctrl.from_upper) begin
         data_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[src/positional_array_list.sv]
// Top level of the positional array list: request decode, cell row and result register.
//
// Requests arrive on the req_ channel (op, position, value) and each one
// produces exactly one transfer on the rsp_ channel carrying read_value,
// status, entry_count, is_empty and is_full.
// Entries live in a row of cells; an insert shifts every cell above the
// position up by one and a remove shifts them down, all in the same cycle.
// A valid response follows in the cycle after the request transfer, and the
// block sustains one request per cycle while the receiver does not stall, set by
// the update of the cell row and the one-deep response register.
// A new request is taken whenever the response register is empty or its
// content is being transferred in the same cycle; while the receiver stalls,
// the response holds and further requests wait.
// The capacity register sits at byte address 0 of the APB-style port; the user
// must write it only while the block is idle, which the block itself does not enforce.
// Synchronous reset empties the list, drops any pending response and sets the
// capacity to 32. Entry contents are not cleared; positions beyond the count
// are never read.
module positional_array_list (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic [pal_pkg::POS_W-1:0]    req_position,
   input  logic signed [pal_pkg::WORD_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [pal_pkg::WORD_W-1:0] rsp_read_value,
   output logic [1:0]                   rsp_status,
   output logic [pal_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pal_pkg::ADDR_W-1:0]   paddr,
   input  logic [pal_pkg::CSR_W-1:0]    pwdata,
   output logic [pal_pkg::CSR_W-1:0]    prdata,
   output logic                         pready
);
   import pal_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   word_type         rsp_read_value_ff;
   word_type         rsp_read_value_in;
   logic [1:0]       rsp_status_ff;
   logic [1:0]       rsp_status_in;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_empty_ff;
   logic             rsp_empty_in;
   logic             rsp_full_ff;
   logic             rsp_full_in;

   logic             accept;
   logic             csr_write;
   logic [CAP_W-1:0] eff_cap;
   logic [POS_W-1:0] pos_idx;
   logic [POS_W:0]   count_p1;
   logic             pos_zero;
   logic             pos_in_list;
   logic             pos_in_ins;
   logic             list_full;
   logic             do_write;
   logic             do_insert;
   logic             do_remove;
   word_type         cell_data [DEPTH];

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr == CSR_CAPACITY) ? CSR_W'(capacity_ff) : '0;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && paddr == CSR_CAPACITY) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   assign eff_cap = (capacity_ff > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign pos_idx     = req_position - POS_W'(1);
   assign count_p1    = {1'b0, POS_W'(count_ff)} + (POS_W + 1)'(1);
   assign pos_zero    = (req_position == '0);
   assign pos_in_list = !pos_zero && (POS_W'(req_position) <= POS_W'(count_ff));
   assign pos_in_ins  = !pos_zero && ({1'b0, req_position} <= count_p1);
   assign list_full   = (CAP_W'(count_ff) >= eff_cap);

   always_comb begin
      rsp_status_in     = ST_DONE;
      rsp_read_value_in = '0;
      do_write          = 1'b0;
      do_insert         = 1'b0;
      do_remove         = 1'b0;
      count_in          = count_ff;
      case (req_op)
         OP_READ: begin
            if (!pos_in_list) begin
               rsp_status_in     = ST_BADPOS;
               rsp_read_value_in = '1;
            end else begin
               rsp_read_value_in = cell_data[pos_idx[IDX_W-1:0]];
            end
         end
         OP_WRITE: begin
            if (!pos_in_list) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               do_write = accept;
            end
         end
         OP_INSERT: begin
            if (!pos_in_ins) begin
               rsp_status_in = ST_BADPOS;
            end else if (list_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               do_insert = accept;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (!pos_in_list) begin
               rsp_status_in = ST_BADPOS;
            end else begin
               do_remove = accept;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         default: begin
            rsp_status_in = ST_BADPOS;
         end
      endcase
      rsp_empty_in = (count_in == '0);
      rsp_full_in  = (CAP_W'(count_in) >= eff_cap);
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      word_type      lower_data;
      word_type      upper_data;

      assign ctrl.load       = (do_write || do_insert) && (POS_W'(i) == pos_idx);
      assign ctrl.from_lower = do_insert && (POS_W'(i) > pos_idx);
      assign ctrl.from_upper = do_remove && (POS_W'(i) >= pos_idx);

      if (i == 0) begin : g_first
         assign lower_data = cell_data[i];
      end else begin : g_mid_lo
         assign lower_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper_data = cell_data[i];
      end else begin : g_mid_hi
         assign upper_data = cell_data[i+1];
      end

      pal_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_data  (word_type'(req_value)),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .data       (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_count_ff      <= count_in;
         rsp_empty_ff      <= rsp_empty_in;
         rsp_full_ff       <= rsp_full_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Entry count exceeds the row depth.");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("Entry count changed without a request transfer.");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid && rsp_entry_count == count_ff)
      else $error("Response missing or inconsistent with the entry count.");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("Empty flag disagrees with the reported count.");

endmodule

[test/tb_positional_array_list.sv]
// Testbench for the positional array list: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module tb_positional_array_list;
   import pal_pkg::*;

   typedef struct {
      logic signed [WORD_W-1:0] read_value;
      logic [1:0]               status;
      logic [CNT_W-1:0]         entry_count;
      logic                     is_empty;
      logic                     is_full;
   } list_result_type;

   localparam int CHUNK_ITEMS = 130;
   localparam int CHUNKS      = 5;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_op = OP_READ;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_read_value;
   logic [1:0]               rsp_status;
   logic [CNT_W-1:0]         rsp_entry_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [CSR_W-1:0]         pwdata = '0;
   logic [CSR_W-1:0]         prdata;
   logic                     pready;

   logic signed [WORD_W-1:0] list_words [DEPTH];
   int                       list_len = 0;
   int                       cap_setting = CAP_RESET;
   list_result_type          expected_results [$];

   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int error_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int capacity_writes = 0;
   int full_refusals = 0;
   int bad_positions = 0;

   positional_array_list dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   task automatic report_failure(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_failure($sformatf("%s is %0h, predicted %0h", name, got, want));
   endtask

   function automatic list_result_type apply_list_request(input logic [1:0] op,
                                                          input logic [POS_W-1:0] pos,
                                                          input logic signed [WORD_W-1:0] val);
      list_result_type res;
      int p;
      int lim;
      p = pos;
      lim = (cap_setting > DEPTH) ? DEPTH : cap_setting;
      res.read_value = '0;
      res.status = ST_DONE;
      case (op)
         OP_READ: begin
            if (p == 0 || p > list_len) begin
               res.status = ST_BADPOS;
               res.read_value = -1;
            end else begin
               res.read_value = list_words[p-1];
            end
         end
         OP_WRITE: begin
            if (p == 0 || p > list_len)
               res.status = ST_BADPOS;
            else
               list_words[p-1] = val;
         end
         OP_INSERT: begin
            if (p == 0 || p > list_len + 1) begin
               res.status = ST_BADPOS;
            end else if (list_len >= lim) begin
               res.status = ST_FULL;
            end else begin
               for (int i = list_len; i >= p; i--)
                  list_words[i] = list_words[i-1];
               list_words[p-1] = val;
               list_len++;
            end
         end
         default: begin
            if (p == 0 || p > list_len) begin
               res.status = ST_BADPOS;
            end else begin
               for (int i = p - 1; i + 1 < list_len; i++)
                  list_words[i] = list_words[i+1];
               list_len--;
            end
         end
      endcase
      res.entry_count = CNT_W'(list_len);
      res.is_empty = (list_len == 0);
      res.is_full = (list_len >= lim);
      return res;
   endfunction

   function automatic logic signed [WORD_W-1:0] random_word();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -1;
         3: return 0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [WORD_W-1:0] val);
      int gap;
      list_result_type want;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_position <= pos;
      req_value <= val;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      want = apply_list_request(op, pos, val);
      expected_results.push_back(want);
      requests_sent++;
      if (want.status == ST_FULL)
         full_refusals++;
      if (want.status == ST_BADPOS)
         bad_positions++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_results();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_CAPACITY;
      pwdata <= CSR_W'(cap);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      cap_setting = cap;
      capacity_writes++;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field("capacity readback", 32'(prdata[CAP_W-1:0]), 32'(cap));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_failure("response transfer with no request outstanding");
         end else begin
            want = expected_results.pop_front();
            check_field("read_value", rsp_read_value, want.read_value);
            check_field("status", 32'(rsp_status), 32'(want.status));
            check_field("entry_count", 32'(rsp_entry_count), 32'(want.entry_count));
            check_field("is_empty", 32'(rsp_is_empty), 32'(want.is_empty));
            check_field("is_full", 32'(rsp_is_full), 32'(want.is_full));
            responses_checked++;
         end
      end
   end

   task automatic test_empty_and_edges();
      send_request(OP_READ, 6'd0, 0);
      send_request(OP_READ, 6'd1, 0);
      send_request(OP_WRITE, 6'd1, 32'sh1234_5678);
      send_request(OP_REMOVE, 6'd1, 0);
      send_request(OP_INSERT, 6'd0, 5);
      send_request(OP_INSERT, 6'd2, 6);
      send_request(OP_INSERT, 6'd1, 32'sh8000_0000);
      send_request(OP_INSERT, 6'd2, 32'sh7fff_ffff);
      send_request(OP_INSERT, 6'd1, 0);
      send_request(OP_INSERT, 6'd2, -1);
      for (int p = 1; p <= 5; p++)
         send_request(OP_READ, POS_W'(p), 0);
      send_request(OP_READ, 6'd63, 32'shffff_ffff);
      send_request(OP_WRITE, 6'd4, 32'sh5555_5555);
      send_request(OP_WRITE, 6'd5, 32'shaaaa_aaaa);
      send_request(OP_REMOVE, 6'd2, 0);
      send_request(OP_REMOVE, 6'd3, 0);
      send_request(OP_INSERT, 6'd63, 7);
      send_request(OP_READ, 6'd1, 0);
      send_request(OP_READ, 6'd2, 0);
      send_request(OP_REMOVE, 6'd1, 0);
      send_request(OP_REMOVE, 6'd1, 0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(6'd1);
      send_request(OP_INSERT, 6'd1, 11);
      send_request(OP_INSERT, 6'd1, 12);
      send_request(OP_INSERT, 6'd3, 13);
      write_capacity(6'd0);
      send_request(OP_INSERT, 6'd1, 14);
      send_request(OP_READ, 6'd1, 0);
      send_request(OP_REMOVE, 6'd1, 0);
      send_request(OP_INSERT, 6'd1, 15);
      write_capacity(6'd32);
      for (int k = 0; k < 3; k++)
         send_request(OP_INSERT, 6'd1, 20 + k);
      write_capacity(6'd2);
      send_request(OP_INSERT, 6'd2, 30);
      send_request(OP_REMOVE, 6'd3, 0);
      send_request(OP_INSERT, 6'd1, 31);
      send_request(OP_REMOVE, 6'd1, 0);
      send_request(OP_INSERT, 6'd3, 32);
      send_request(OP_READ, 6'd3, 0);
      write_capacity(6'd63);
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      int pick;
      int insert_pct;
      logic [1:0] op;
      logic [POS_W-1:0] pos;
      send_idle_pct = sender_pct;
      rcv_idle_pct = receiver_pct;
      for (int c = 0; c < CHUNKS; c++) begin
         case (c)
            0: write_capacity(6'd63);
            1: write_capacity(6'd1);
            2: write_capacity(CAP_W'($urandom_range(2, 31)));
            3: write_capacity(6'd32);
            default: write_capacity(CAP_W'($urandom_range(0, 63)));
         endcase
         insert_pct = (c == 0) ? 60 : 30;
         for (int n = 0; n < CHUNK_ITEMS; n++) begin
            if ($urandom_range(199) == 0)
               drain_results();
            pick = $urandom_range(99);
            if (pick < 8) begin
               op = 2'($urandom_range(3));
               pos = POS_W'($urandom_range(63));
            end else begin
               pick = $urandom_range(99);
               if (pick < insert_pct)
                  op = OP_INSERT;
               else if (pick < insert_pct + 25)
                  op = OP_REMOVE;
               else if (pick < insert_pct + 47)
                  op = OP_READ;
               else
                  op = OP_WRITE;
               if (op == OP_INSERT)
                  pos = POS_W'($urandom_range(1, list_len + 1));
               else if (list_len == 0)
                  pos = 6'd1;
               else
                  pos = POS_W'($urandom_range(1, list_len));
            end
            send_request(op, pos, random_word());
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_edges();
      test_capacity_limits();
      test_random_traffic(18, 83);
      test_random_traffic(83, 18);
      test_random_traffic(0, 0);
      drain_results();
      $display("Sent %0d requests over %0d capacity settings and three idling mixes.",
               requests_sent, capacity_writes);
      $display("Checked %0d responses: %0d refused as full, %0d with a bad position.",
               responses_checked, full_refusals, bad_positions);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d responses outstanding.", expected_results.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
